[rtl/core/qdsw_pkg.sv]
package qdsw_pkg;

    localparam int WINDOW_DEPTH_DEF = 9;
    localparam int WHEEL_COUNT_DEF  = 3;
    localparam int OUT_WHEELS       = 3;
    localparam int COUNT_W          = 32;
    localparam int MISS_W           = 16;
    localparam int PHASE_W          = 2;
    localparam int FUNC_W           = 2;
    localparam int BITS_W           = 3;
    localparam int IN_TDATA_W       = 8;
    localparam int IN_TUSER_W       = FUNC_W;
    localparam int OUT_TDATA_W      = OUT_WHEELS * (2 * COUNT_W + MISS_W);

    localparam logic [MISS_W-1:0] MISS_MAX = '1;

    // Gray code {B,A} to phase
    localparam logic [PHASE_W-1:0] GRAY_TO_PHASE [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [PHASE_W-1:0] {
        DELTA_HOLD = 2'd0,
        DELTA_UP   = 2'd1,
        DELTA_MISS = 2'd2,
        DELTA_DOWN = 2'd3
    } t_delta;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef struct packed {
        logic sample;
        logic tick;
        logic clear;
    } t_wheel_ctl;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] speed;
        logic [MISS_W-1:0]  misses;
    } t_wheel_res;

endpackage

[rtl/core/qdsw_wheel.sv]
module qdsw_wheel import qdsw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_wheel_ctl         i_ctl,
    input  logic               i_a,
    input  logic               i_b,
    input  logic [COUNT_W-1:0] i_oldest,
    output logic [COUNT_W-1:0] o_count,
    output t_wheel_res         o_res
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    t_dir               r_dir, n_dir;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_speed, n_speed;
    logic [MISS_W-1:0]  r_misses, n_misses;
    logic [PHASE_W-1:0] phase_new;
    t_delta             delta;

    always_comb begin
        phase_new = GRAY_TO_PHASE[{i_b, i_a}];
        delta     = t_delta'(phase_new - r_phase);
        n_phase   = r_phase;
        n_dir     = r_dir;
        n_count   = r_count;
        n_speed   = r_speed;
        n_misses  = r_misses;
        if (i_ctl.sample) begin
            n_phase = phase_new;
            unique case (delta)
                DELTA_HOLD: begin
                end
                DELTA_UP: begin
                    n_dir   = DIR_UP;
                    n_count = r_count + COUNT_W'(1);
                end
                DELTA_DOWN: begin
                    n_dir   = DIR_DOWN;
                    n_count = r_count - COUNT_W'(1);
                end
                DELTA_MISS: begin
                    // skipped phase: move two steps the way we last went
                    if (r_dir == DIR_UP) begin
                        n_count = r_count + COUNT_W'(2);
                    end else if (r_dir == DIR_DOWN) begin
                        n_count = r_count - COUNT_W'(2);
                    end
                    if (r_misses != MISS_MAX) begin
                        n_misses = r_misses + MISS_W'(1);
                    end
                end
            endcase
        end
        if (i_ctl.tick) begin
            n_speed = r_count - i_oldest;
        end
        if (i_ctl.clear) begin
            n_count  = '0;
            n_misses = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_dir    <= DIR_NONE;
            r_count  <= '0;
            r_speed  <= '0;
            r_misses <= '0;
        end else begin
            r_phase  <= n_phase;
            r_dir    <= n_dir;
            r_count  <= n_count;
            r_speed  <= n_speed;
            r_misses <= n_misses;
        end
    end

    assign o_count = r_count;
    assign o_res   = '{count: n_count, speed: n_speed, misses: n_misses};

    a_tick_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.tick && !i_ctl.clear |=> r_count == $past(r_count))
        else $error("count moved on a speed tick");

    a_misses_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.clear |=> r_misses >= $past(r_misses))
        else $error("miss count fell without a clear");

endmodule

[rtl/core/qdsw_hist.sv]
module qdsw_hist import qdsw_pkg::*; #(
    parameter int DEPTH  = WINDOW_DEPTH_DEF,
    parameter int WHEELS = WHEEL_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_tick,
    input  logic [WHEELS*COUNT_W-1:0] i_wr_row,
    output logic [WHEELS*COUNT_W-1:0] o_oldest
);

    localparam int ROW_W = WHEELS * COUNT_W;
    localparam int PTR_W = $clog2(DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [PTR_W-1:0] rd_addr;
    logic [ROW_W-1:0] r_rdata;

    // prefetch the row after the next write slot; it is the oldest at the next tick
    assign n_ptr   = i_tick ? ptr_inc(r_ptr) : r_ptr;
    assign rd_addr = ptr_inc(n_ptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_valid <= '0;
        end else begin
            r_ptr <= n_ptr;
            if (i_tick) begin
                r_valid[r_ptr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick) begin
            r_mem[r_ptr] <= i_wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick && rd_addr == r_ptr) begin
            r_rdata <= i_wr_row;
        end else if (r_valid[rd_addr]) begin
            r_rdata <= r_mem[rd_addr];
        end else begin
            r_rdata <= '0;
        end
    end

    assign o_oldest = r_rdata;

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(DEPTH - 1))
        else $error("history pointer beyond window");

    a_row_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick |=> r_valid[$past(r_ptr)] && r_ptr != $past(r_ptr))
        else $error("history write not recorded");

endmodule

[rtl/core/quadrature_decode_speed_window.sv]
// Pipeline: an accepted request is held in the input register, then its result is
// captured in the result register, which drives o_m_axis_tvalid; a stall holds both.
// Throughput: one request per cycle unless output stalls; per-wheel decode and count
// update is a single pass, and the oldest history row is prefetched from ring memory.
// Reset: synchronous, active low; clears counts, misses, speeds, phases, directions,
// the ring pointer and one valid bit per history row, so no clearing pass is needed.
module quadrature_decode_speed_window import qdsw_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int WHEEL_COUNT  = WHEEL_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [2:0] phase_a_bits, [5:3] phase_b_bits, [7:6] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] func
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [95:0] wheel0..2_count, [191:96] wheel0..2_speed, [239:192] wheel0..2_misses
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int ROW_W = WHEEL_COUNT * COUNT_W;

    logic              r_s1_valid;
    logic [FUNC_W-1:0] r_s1_func;
    logic [BITS_W-1:0] r_s1_a;
    logic [BITS_W-1:0] r_s1_b;
    logic              s1_fire;
    logic              in_fire;
    t_wheel_ctl        ctl;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;

    logic [ROW_W-1:0] wr_row;
    logic [ROW_W-1:0] oldest;
    t_wheel_res       res [WHEEL_COUNT];

    assign s1_fire         = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_fire;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_func <= i_s_axis_tuser[FUNC_W-1:0];
            r_s1_a    <= i_s_axis_tdata[BITS_W-1:0];
            r_s1_b    <= i_s_axis_tdata[2*BITS_W-1:BITS_W];
        end
    end

    always_comb begin
        ctl = '0;
        if (s1_fire) begin
            unique case (t_func'(r_s1_func))
                FUNC_SAMPLE: ctl.sample = 1'b1;
                FUNC_TICK:   ctl.tick   = 1'b1;
                FUNC_CLEAR:  ctl.clear  = 1'b1;
                default: begin
                end
            endcase
        end
    end

    for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_wheel
        logic a_bit, b_bit;
        if (w < BITS_W) begin : g_live
            assign a_bit = r_s1_a[w];
            assign b_bit = r_s1_b[w];
        end else begin : g_idle
            assign a_bit = 1'b0;
            assign b_bit = 1'b0;
        end

        qdsw_wheel u_wheel (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_a      (a_bit),
            .i_b      (b_bit),
            .i_oldest (oldest[w*COUNT_W +: COUNT_W]),
            .o_count  (wr_row[w*COUNT_W +: COUNT_W]),
            .o_res    (res[w])
        );
    end

    qdsw_hist #(
        .DEPTH  (WINDOW_DEPTH),
        .WHEELS (WHEEL_COUNT)
    ) u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (ctl.tick),
        .i_wr_row (wr_row),
        .o_oldest (oldest)
    );

    for (genvar w = 0; w < OUT_WHEELS; w++) begin : g_out
        if (w < WHEEL_COUNT) begin : g_used
            assign n_out_data[w*COUNT_W +: COUNT_W]                       = res[w].count;
            assign n_out_data[(OUT_WHEELS + w)*COUNT_W +: COUNT_W]        = res[w].speed;
            assign n_out_data[2*OUT_WHEELS*COUNT_W + w*MISS_W +: MISS_W]  = res[w].misses;
        end else begin : g_unused
            assign n_out_data[w*COUNT_W +: COUNT_W]                       = '0;
            assign n_out_data[(OUT_WHEELS + w)*COUNT_W +: COUNT_W]        = '0;
            assign n_out_data[2*OUT_WHEELS*COUNT_W + w*MISS_W +: MISS_W]  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_fire |=> r_s1_valid && $stable(r_s1_func) && $stable(r_s1_a))
        else $error("staged request lost while stalled");

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid)
        else $error("result not presented after update");

endmodule
